// ===== src/rvu_pkg.sv =====
package rvu_pkg;

  // Input item: one ray hit.
  typedef struct packed {
    logic signed [15:0] incident_x;
    logic signed [15:0] incident_y;
    logic signed [15:0] incident_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic [15:0]        material_index;
  } hit_t;

  // Result item: one refracted direction with its flags.
  typedef struct packed {
    logic signed [15:0] refracted_x;
    logic signed [15:0] refracted_y;
    logic signed [15:0] refracted_z;
    logic               total_reflection;
    logic               from_inside;
    logic               saturated;
  } ray_t;

  // Classified item handed from the front part to the back part.
  typedef struct packed {
    logic [2:0][15:0] inc;     // incident components, signed Q2.14
    logic [2:0][16:0] nrm;     // normal, negated when inside, signed
    logic [14:0]      cosi;    // |cos| in Q.14
    logic [15:0]      eta_i;   // index on the incident side
    logic [15:0]      eta_t;   // index on the far side, never zero
    logic             inner;
  } job_t;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic signed [33:0] ONE_Q28 = 34'sd268435456;
  localparam logic [15:0]        ONE_Q14 = 16'd16384;

endpackage

// ===== src/rvu_front.sv =====
module rvu_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           hit_valid,
  output logic           hit_stall,
  input  rvu_pkg::hit_t  hit,
  input  logic [15:0]    outer_index,
  input  logic           q_full,
  output logic           q_push,
  output rvu_pkg::job_t  q_data
);
  import rvu_pkg::*;

  logic               s1_valid;
  hit_t               s1_hit;
  logic signed [31:0] s1_prod [3];
  logic               front_en;

  logic signed [33:0] dot;
  logic signed [33:0] dot_c;
  logic [28:0]        abs_c;
  logic [29:0]        abs_r;
  logic               inner;
  logic [15:0]        eta_t;

  // The product stage may load whenever its item can move on.
  assign front_en  = !s1_valid || !q_full;
  assign hit_stall = !front_en;
  assign q_push    = s1_valid && !q_full;

  // First stage: register the three dot product terms.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (front_en) begin
      s1_valid <= hit_valid;
    end
    if (front_en) begin
      s1_hit     <= hit;
      s1_prod[0] <= 32'(hit.incident_x) * 32'(hit.normal_x);
      s1_prod[1] <= 32'(hit.incident_y) * 32'(hit.normal_y);
      s1_prod[2] <= 32'(hit.incident_z) * 32'(hit.normal_z);
    end
  end

  // Second stage: sum, clamp and classify the hit.
  always_comb begin
    dot = 34'(s1_prod[0]) + 34'(s1_prod[1]) + 34'(s1_prod[2]);
    if (dot > ONE_Q28) begin
      dot_c = ONE_Q28;
    end else if (dot < -ONE_Q28) begin
      dot_c = -ONE_Q28;
    end else begin
      dot_c = dot;
    end
    // A positive dot product means the ray leaves the material.
    inner = dot_c > 34'sd0;
    abs_c = inner ? 29'(dot_c) : 29'(-dot_c);
    abs_r = 30'(abs_c) + 30'd8192;

    q_data.inc[0] = s1_hit.incident_x;
    q_data.inc[1] = s1_hit.incident_y;
    q_data.inc[2] = s1_hit.incident_z;
    q_data.nrm[0] = inner ? 17'(-17'(s1_hit.normal_x)) : 17'(s1_hit.normal_x);
    q_data.nrm[1] = inner ? 17'(-17'(s1_hit.normal_y)) : 17'(s1_hit.normal_y);
    q_data.nrm[2] = inner ? 17'(-17'(s1_hit.normal_z)) : 17'(s1_hit.normal_z);
    q_data.cosi   = abs_r[28:14];
    q_data.inner  = inner;
    q_data.eta_i  = inner ? s1_hit.material_index : outer_index;
    eta_t         = inner ? outer_index : s1_hit.material_index;
    // A zero divisor index counts as one LSB.
    q_data.eta_t  = (eta_t == 16'd0) ? 16'd1 : eta_t;
  end

endmodule

// ===== src/rvu_queue.sv =====
module rvu_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rvu_pkg::job_t din,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output rvu_pkg::job_t dout
);
  import rvu_pkg::*;

  job_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign full    = count == (QPTR_W + 1)'(QDEPTH);
  assign empty   = count == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  // Item storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

// ===== src/rvu_back.sv =====
module rvu_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  output logic          q_pop,
  input  rvu_pkg::job_t q_data,
  output logic          ray_valid,
  input  logic          ray_stall,
  output rvu_pkg::ray_t ray
);
  import rvu_pkg::*;

  localparam int DIV_N = 32;
  localparam int SQ_N  = 15;

  typedef struct packed {
    logic [2:0][15:0] inc;
    logic [2:0][16:0] nrm;
    logic [14:0]      cosi;
    logic             inner;
    logic [15:0]      d;
    logic [15:0]      rem;
    logic [31:0]      num;
    logic [31:0]      quo;
  } div_t;

  typedef struct packed {
    logic [2:0][15:0] inc;
    logic [2:0][16:0] nrm;
    logic             inner;
    logic             totref;
    logic [31:0]      eta;
    logic [46:0]      ec;
    logic [29:0]      k;
    logic [16:0]      rem;
    logic [14:0]      root;
  } sq_t;

  logic en;
  assign en    = !(ray_valid && ray_stall);
  assign q_pop = en && !q_empty;

  // Divider pipeline: one quotient bit per stage.
  div_t dv   [DIV_N+1];
  logic dval [DIV_N+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dval[0] <= 1'b0;
    end else if (en) begin
      dval[0] <= !q_empty;
    end
    if (en) begin
      dv[0].inc   <= q_data.inc;
      dv[0].nrm   <= q_data.nrm;
      dv[0].cosi  <= q_data.cosi;
      dv[0].inner <= q_data.inner;
      dv[0].d     <= q_data.eta_t;
      dv[0].rem   <= '0;
      dv[0].num   <= {q_data.eta_i, 16'd0};
      dv[0].quo   <= '0;
    end
  end

  for (genvar j = 1; j <= DIV_N; j++) begin : g_div
    logic [16:0] rsh;
    logic        ge;
    div_t        stage_next;
    assign rsh = {dv[j-1].rem, dv[j-1].num[31]};
    assign ge  = rsh >= {1'b0, dv[j-1].d};

    // Shift in one numerator bit and take one quotient bit.
    always_comb begin
      stage_next     = dv[j-1];
      stage_next.num = {dv[j-1].num[30:0], 1'b0};
      stage_next.rem = ge ? 16'(rsh - {1'b0, dv[j-1].d}) : rsh[15:0];
      stage_next.quo = {dv[j-1].quo[30:0], ge};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dval[j] <= 1'b0;
      end else if (en) begin
        dval[j] <= dval[j-1];
      end
      if (en) begin
        dv[j] <= stage_next;
      end
    end
  end

  // Square of eta and one minus cos squared.
  logic             m1_valid;
  logic [2:0][15:0] m1_inc;
  logic [2:0][16:0] m1_nrm;
  logic             m1_inside;
  logic [14:0]      m1_cosi;
  logic [31:0]      m1_eta;
  logic [63:0]      m1_eta2;
  logic [28:0]      m1_s28;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
    end else if (en) begin
      m1_valid <= dval[DIV_N];
    end
    if (en) begin
      m1_inc    <= dv[DIV_N].inc;
      m1_nrm    <= dv[DIV_N].nrm;
      m1_inside <= dv[DIV_N].inner;
      m1_cosi   <= dv[DIV_N].cosi;
      m1_eta    <= dv[DIV_N].quo;
      m1_eta2   <= 64'(dv[DIV_N].quo) * 64'(dv[DIV_N].quo);
      m1_s28    <= 29'(30'd268435456 - 30'(dv[DIV_N].cosi) * 30'(dv[DIV_N].cosi));
    end
  end

  // Partial products of eta squared times s, and eta times cos.
  logic             m2_valid;
  logic [2:0][15:0] m2_inc;
  logic [2:0][16:0] m2_nrm;
  logic             m2_inside;
  logic [31:0]      m2_eta;
  logic [60:0]      m2_ph;
  logic [60:0]      m2_pl;
  logic [46:0]      m2_ec;

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_valid <= 1'b0;
    end else if (en) begin
      m2_valid <= m1_valid;
    end
    if (en) begin
      m2_inc    <= m1_inc;
      m2_nrm    <= m1_nrm;
      m2_inside <= m1_inside;
      m2_eta    <= m1_eta;
      m2_ph     <= 61'(m1_eta2[63:32]) * 61'(m1_s28);
      m2_pl     <= 61'(m1_eta2[31:0]) * 61'(m1_s28);
      m2_ec     <= 47'(m1_eta) * 47'(m1_cosi);
    end
  end

  // Total reflection test and k, then the square root pipeline.
  logic [61:0] t28;
  logic        tr;
  assign t28 = {1'b0, m2_ph} + 62'(m2_pl[60:32]);
  assign tr  = t28 > 62'd268435456;

  sq_t  sq   [SQ_N+1];
  logic sqv  [SQ_N+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      sqv[0] <= 1'b0;
    end else if (en) begin
      sqv[0] <= m2_valid;
    end
    if (en) begin
      sq[0].inc    <= m2_inc;
      sq[0].nrm    <= m2_nrm;
      sq[0].inner  <= m2_inside;
      sq[0].totref <= tr;
      sq[0].eta    <= m2_eta;
      sq[0].ec     <= m2_ec;
      sq[0].k      <= {1'b0, 29'(29'd268435456 - t28[28:0])};
      sq[0].rem    <= '0;
      sq[0].root   <= '0;
    end
  end

  for (genvar j = 1; j <= SQ_N; j++) begin : g_sqrt
    logic [18:0] rsh;
    logic [18:0] trial;
    logic        ge;
    sq_t         stage_next;
    assign rsh   = {sq[j-1].rem, sq[j-1].k[29:28]};
    assign trial = {2'b00, sq[j-1].root, 2'b01};
    assign ge    = rsh >= trial;

    // Bring down two radicand bits and take one root bit.
    always_comb begin
      stage_next      = sq[j-1];
      stage_next.k    = {sq[j-1].k[27:0], 2'b00};
      stage_next.rem  = ge ? 17'(rsh - trial) : rsh[16:0];
      stage_next.root = {sq[j-1].root[13:0], ge};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sqv[j] <= 1'b0;
      end else if (en) begin
        sqv[j] <= sqv[j-1];
      end
      if (en) begin
        sq[j] <= stage_next;
      end
    end
  end

  // m = eta * cos - sqrt(k), Q.30.
  logic               m4_valid;
  logic [2:0][15:0]   m4_inc;
  logic [2:0][16:0]   m4_nrm;
  logic               m4_inside;
  logic               m4_totref;
  logic [31:0]        m4_eta;
  logic signed [47:0] m4_m30;

  always_ff @(posedge clk) begin
    if (rst) begin
      m4_valid <= 1'b0;
    end else if (en) begin
      m4_valid <= sqv[SQ_N];
    end
    if (en) begin
      m4_inc    <= sq[SQ_N].inc;
      m4_nrm    <= sq[SQ_N].nrm;
      m4_inside <= sq[SQ_N].inner;
      m4_totref <= sq[SQ_N].totref;
      m4_eta    <= sq[SQ_N].eta;
      m4_m30    <= $signed({1'b0, sq[SQ_N].ec}) - $signed({17'd0, sq[SQ_N].root, 16'd0});
    end
  end

  // Component products, with m split in two halves.
  logic               m5_valid;
  logic               m5_inside;
  logic               m5_totref;
  logic signed [48:0] m5_p0  [3];
  logic signed [41:0] m5_plo [3];
  logic signed [40:0] m5_phi [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      m5_valid <= 1'b0;
    end else if (en) begin
      m5_valid <= m4_valid;
    end
    if (en) begin
      m5_inside <= m4_inside;
      m5_totref <= m4_totref;
      for (int i = 0; i < 3; i++) begin
        m5_p0[i]  <= 49'($signed(m4_inc[i])) * 49'($signed({1'b0, m4_eta}));
        m5_plo[i] <= 42'($signed(m4_nrm[i])) * 42'($signed({1'b0, m4_m30[23:0]}));
        m5_phi[i] <= 41'($signed(m4_nrm[i])) * 41'($signed(m4_m30[47:24]));
      end
    end
  end

  // Sum, round half up, saturate.
  logic signed [65:0] acc  [3];
  logic signed [35:0] rnd  [3];
  logic signed [15:0] comp [3];
  logic [2:0]         clip;
  ray_t               ray_next;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = (66'(m5_p0[i]) <<< 14) + 66'(m5_plo[i]) + (66'(m5_phi[i]) <<< 24)
               + 66'sd536870912;
      rnd[i] = acc[i][65:30];
      if (rnd[i] > 36'sd32767) begin
        comp[i] = 16'sh7fff;
        clip[i] = 1'b1;
      end else if (rnd[i] < -36'sd32768) begin
        comp[i] = 16'sh8000;
        clip[i] = 1'b1;
      end else begin
        comp[i] = rnd[i][15:0];
        clip[i] = 1'b0;
      end
    end
    ray_next.from_inside = m5_inside;
    if (m5_totref) begin
      ray_next.refracted_x      = ONE_Q14;
      ray_next.refracted_y      = '0;
      ray_next.refracted_z      = '0;
      ray_next.total_reflection = 1'b1;
      ray_next.saturated        = 1'b0;
    end else begin
      ray_next.refracted_x      = comp[0];
      ray_next.refracted_y      = comp[1];
      ray_next.refracted_z      = comp[2];
      ray_next.total_reflection = 1'b0;
      ray_next.saturated        = |clip;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      ray_valid <= 1'b0;
    end else if (en) begin
      ray_valid <= m5_valid;
    end
    if (en) begin
      ray <= ray_next;
    end
  end

endmodule

// ===== src/refraction_vector_unit.sv =====
// Snell refraction unit: one ray hit in, one refracted direction out.
// Hit channel (hit_valid, hit_stall, hit): an item is taken at a clock edge
// with hit_valid high and hit_stall low. Ray channel (ray_valid, ray_stall,
// ray) works the same way, with the receiver driving ray_stall.
// Configuration (cfg_valid, cfg_ready, cfg_data) writes the outer index,
// unsigned Q4.12; cfg_ready is always high. Write it only while idle.
// Throughput is one item per cycle while the receiver does not stall. From
// input to output an item passes the front register for the dot product
// terms, the queue, the divider (input register and 32 one-bit stages), two
// multiply stages, the square root (k register and 15 stages), and three
// stages for m, the component products, and the round into the output
// register.
// When the receiver stalls, the back pipeline holds in place and the
// four-entry queue keeps taking items until it fills; then hit_stall rises.
// Synchronous reset empties all stages and the queue and sets the outer
// index to 1.0.
module refraction_vector_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          hit_valid,
  output logic          hit_stall,
  input  rvu_pkg::hit_t hit,
  output logic          ray_valid,
  input  logic          ray_stall,
  output rvu_pkg::ray_t ray,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [15:0]   cfg_data
);
  import rvu_pkg::*;

  logic [15:0] outer_index;
  logic        q_full;
  logic        q_push;
  logic        q_empty;
  logic        q_pop;
  job_t        q_in;
  job_t        q_out;

  // Outer index register.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      outer_index <= 16'd4096;
    end else if (cfg_valid) begin
      outer_index <= cfg_data;
    end
  end

  rvu_front u_front (
    .clk         (clk),
    .rst         (rst),
    .hit_valid   (hit_valid),
    .hit_stall   (hit_stall),
    .hit         (hit),
    .outer_index (outer_index),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_in)
  );

  rvu_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_in),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .dout  (q_out)
  );

  rvu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_data    (q_out),
    .ray_valid (ray_valid),
    .ray_stall (ray_stall),
    .ray       (ray)
  );

`ifndef SYNTH
  // Reset leaves no result pending.
  a_reset_clear: assert property (@(posedge clk) rst |=> !ray_valid)
    else $error("result valid after reset");

  // A total reflection result is the fixed direction with no clipping.
  a_totref_form: assert property (@(posedge clk) disable iff (rst)
    (ray_valid && ray.total_reflection) |->
      (ray.refracted_x == 16'sd16384 && ray.refracted_y == 16'sd0 &&
       ray.refracted_z == 16'sd0 && !ray.saturated))
    else $error("total reflection result malformed");

  // The front only holds off when the queue is full.
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    hit_stall |-> q_full)
    else $error("input stalled with room in the queue");
`endif

endmodule
